FILE: sv/tac_pkg.sv
// ----------------------------------------------------------------------------
// tac_pkg: shared types, constants and float helpers
// Pair and result records, FSM codes and double-precision pack/round helpers
// used by the tolerance compare block.
// ----------------------------------------------------------------------------
package tac_pkg;

  localparam int unsigned COUNT_BITS_DEF = 32;

  // working mantissa and exponent widths of the shared float datapath
  localparam int unsigned MW = 108;
  localparam int unsigned EW = 14;

  localparam int unsigned MUL_STEPS = 53;
  localparam int unsigned DIV_STEPS = 56;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ABS_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REL_TOL = 2'd1;

  localparam logic [63:0] QNAN    = 64'h7FF8_0000_0000_0000;
  localparam logic [63:0] POS_INF = 64'h7FF0_0000_0000_0000;

  typedef enum logic [1:0] {
    VERDICT_IDENTICAL = 2'd0,
    VERDICT_WITHIN    = 2'd1,
    VERDICT_DIFFERENT = 2'd2
  } verdict_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ADD_ALIGN,
    ST_ADD_SUM,
    ST_MUL_SETUP,
    ST_MUL,
    ST_DIV_SETUP,
    ST_DIV,
    ST_NORM,
    ST_ROUND,
    ST_STEP,
    ST_UPDATE,
    ST_EMIT
  } back_state_e;

  typedef enum logic [2:0] {
    PH_ERR,
    PH_PROD,
    PH_THR,
    PH_DIVX,
    PH_DIVY,
    PH_REL
  } phase_e;

  typedef struct packed {
    logic [63:0] value_a;
    logic [63:0] value_b;
    logic        last_pair;
    logic        differ;   // a != b as doubles
    logic        den_pos;  // |a| > 0
  } pair_t;

  typedef struct packed {
    logic  valid;
    pair_t pair;
  } queue_head_t;

  typedef struct packed {
    logic [63:0] max_abs_error;
    logic [63:0] max_rel_error;
    logic [31:0] worst_position;
    logic [31:0] exceed_count;
    logic        all_exact;
    verdict_e    verdict;
  } result_t;

  function automatic logic is_nan(logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] != 52'd0);
  endfunction

  function automatic logic is_inf(logic [63:0] x);
    return (x[62:52] == 11'h7FF) && (x[51:0] == 52'd0);
  endfunction

  function automatic logic is_zero(logic [63:0] x);
    return x[62:0] == 63'd0;
  endfunction

  // unbiased exponent, subnormals taken at the minimum normal exponent
  function automatic logic signed [EW-1:0] eff_exp(logic [63:0] x);
    logic [10:0] e;
    e = (x[62:52] == 11'd0) ? 11'd1 : x[62:52];
    return $signed({{(EW-11){1'b0}}, e}) - EW'(1023);
  endfunction

  function automatic logic [52:0] mant53(logic [63:0] x);
    return {x[62:52] != 11'd0, x[51:0]};
  endfunction

  function automatic logic [31:0] clamp32(logic [63:0] v);
    return (v > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
  endfunction

  // Round to nearest even and pack. mant is normalized (msb set) and its
  // msb has weight 2^ex. Tiny values are shifted down into the subnormal
  // range; a rounding carry walks into the exponent field.
  function automatic logic [63:0] round_pack(logic sign, logic signed [EW-1:0] ex,
                                             logic [MW-1:0] mant, logic sticky);
    logic signed [EW-1:0] be;
    logic signed [EW-1:0] tmp;
    logic [6:0]           sh;
    logic [MW-1:0]        shifted;
    logic                 lost;
    logic                 guard;
    logic                 rest;
    logic                 inc;
    logic [10:0]          efield;
    logic [62:0]          body;
    be  = ex + EW'(1023);
    tmp = EW'(1) - be;
    if (be < EW'(1)) begin
      sh = (tmp > EW'(127)) ? 7'd127 : tmp[6:0];
    end else begin
      sh = 7'd0;
    end
    shifted = mant >> sh;
    lost    = |(mant & ~({MW{1'b1}} << sh));
    guard   = shifted[MW-54];
    rest    = (|shifted[MW-55:0]) | lost | sticky;
    inc     = guard & (rest | shifted[MW-53]);
    efield  = (be < EW'(1)) ? 11'd0 : be[10:0];
    body    = {efield, shifted[MW-2:MW-53]} + 63'(inc);
    if (be > EW'(2046)) begin
      return {sign, 11'h7FF, 52'd0};
    end
    return {sign, body};
  endfunction

endpackage

FILE: sv/tac_front.sv
// ----------------------------------------------------------------------------
// tac_front: pair intake
// Accepts pairs, classifies equality and the sign of |a|, and holds them in
// a two-entry queue for the arithmetic back end.
// ----------------------------------------------------------------------------
module tac_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  input  logic [127:0]         s_axis_tdata_i,  // value_a [63:0], value_b [127:64]
  input  logic                 s_axis_tlast_i,  // last_pair
  output tac_pkg::queue_head_t head_o,
  input  logic                 pop_i
);

  localparam int unsigned PtrW = $clog2(tac_pkg::QUEUE_DEPTH);

  tac_pkg::pair_t entries_q [tac_pkg::QUEUE_DEPTH];
  tac_pkg::pair_t new_pair;
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]   count_q, count_d;
  logic            push;
  logic            pop;
  logic [63:0]     a;
  logic [63:0]     b;

  assign a = s_axis_tdata_i[63:0];
  assign b = s_axis_tdata_i[127:64];

  // NaN never compares equal; +0 and -0 do
  always_comb begin
    new_pair.value_a   = a;
    new_pair.value_b   = b;
    new_pair.last_pair = s_axis_tlast_i;
    new_pair.differ    = tac_pkg::is_nan(a) || tac_pkg::is_nan(b) ||
                         (!(tac_pkg::is_zero(a) && tac_pkg::is_zero(b)) && (a != b));
    new_pair.den_pos   = !tac_pkg::is_nan(a) && !tac_pkg::is_zero(a);
  end

  assign s_axis_tready_o = (count_q != (PtrW+1)'(tac_pkg::QUEUE_DEPTH));
  assign push            = s_axis_tvalid_i && s_axis_tready_o;
  assign pop             = pop_i && (count_q != '0);

  assign head_o.valid = (count_q != '0);
  assign head_o.pair  = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (PtrW+1)'(push) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entries_q[wr_ptr_q] <= new_pair;
    end
  end

endmodule

FILE: sv/tac_back.sv
// ----------------------------------------------------------------------------
// tac_back: error arithmetic and running summary
// Sequencer over one shared float datapath: align/add, shift-add multiply,
// restoring divide, normalize and round. Keeps the running maxima and counts
// and loads the summary into the output register on a last pair.
// ----------------------------------------------------------------------------
module tac_back #(
  parameter int unsigned COUNT_BITS = tac_pkg::COUNT_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tac_pkg::queue_head_t head_i,
  output logic                 pop_o,
  input  logic [63:0]          abs_tol_i,
  input  logic [63:0]          rel_tol_i,
  output logic                 m_valid_o,
  input  logic                 m_ready_i,
  output tac_pkg::result_t     result_o
);

  localparam int unsigned MW = tac_pkg::MW;
  localparam int unsigned EW = tac_pkg::EW;

  tac_pkg::back_state_e state_q, state_d;
  tac_pkg::phase_e      phase_q, phase_d;

  tac_pkg::pair_t         pair_q, pair_d;
  logic [63:0]            err_q, err_d, thr_q, thr_d, rel_q, rel_d, res_q, res_d;
  logic [63:0]            op_x_q, op_x_d, op_y_q, op_y_d;
  logic                   nsign_q, nsign_d;
  logic signed [EW-1:0]   nexp_q, nexp_d;
  logic [MW-1:0]          nmant_q, nmant_d;
  logic                   nsticky_q, nsticky_d;
  logic [MW-1:0]          add_big_q, add_big_d, add_small_q, add_small_d;
  logic                   add_sub_q, add_sub_d;
  logic [105:0]           acc_q, acc_d;
  logic [52:0]            mcand_q, mcand_d, mplier_q, mplier_d;
  logic [52:0]            dvd_q, dvd_d, dvs_q, dvs_d;
  logic signed [EW-1:0]   dvd_exp_q, dvd_exp_d;
  logic [53:0]            rem_q, rem_d;
  logic [55:0]            quo_q, quo_d;
  logic [5:0]             step_q, step_d;

  logic [63:0]            max_abs_q, max_abs_d, max_rel_q, max_rel_d;
  logic                   worst_seen_q, worst_seen_d;
  logic [COUNT_BITS-1:0]  worst_at_q, worst_at_d, over_q, over_d, pairs_q, pairs_d;
  logic                   exact_q, exact_d;

  logic                   out_valid_q, out_valid_d;
  tac_pkg::result_t       out_q, out_d;

  // datapath helpers
  logic [63:0]            den;
  logic                   swap;
  logic [63:0]            big, small_op;
  logic [EW-1:0]          exp_diff;
  logic [6:0]             align_sh;
  logic [MW-1:0]          small_full, small_sh;
  logic                   align_lost;
  logic [MW-1:0]          sum;
  logic [105:0]           acc_next;
  logic                   div_ge;
  logic [53:0]            div_rem;
  logic [63:0]            rnd;
  logic                   take_abs, take_rel, over_tol;
  logic [COUNT_BITS-1:0]  cnt_max;
  tac_pkg::verdict_e      verdict;

  assign den     = {1'b0, pair_q.value_a[62:0]};
  assign cnt_max = '1;

  // alignment of the smaller magnitude, shifted-out bits folded into bit 0
  assign swap       = op_y_q[62:0] > op_x_q[62:0];
  assign big        = swap ? op_y_q : op_x_q;
  assign small_op   = swap ? op_x_q : op_y_q;
  assign exp_diff   = EW'(tac_pkg::eff_exp(big) - tac_pkg::eff_exp(small_op));
  assign align_sh   = (exp_diff > EW'(127)) ? 7'd127 : exp_diff[6:0];
  assign small_full = {1'b0, tac_pkg::mant53(small_op), {(MW-54){1'b0}}};
  assign small_sh   = small_full >> align_sh;
  assign align_lost = |(small_full & ~({MW{1'b1}} << align_sh));

  assign sum = add_sub_q ? add_big_q - add_small_q : add_big_q + add_small_q;

  assign acc_next = {acc_q[104:0], 1'b0} + (mplier_q[52] ? {53'd0, mcand_q} : 106'd0);

  assign div_ge  = rem_q >= {1'b0, dvs_q};
  assign div_rem = div_ge ? rem_q - {1'b0, dvs_q} : rem_q;

  assign rnd = tac_pkg::round_pack(nsign_q, nexp_q, nmant_q, nsticky_q);

  // all values compared here except thr are non-negative or NaN
  assign take_abs = !tac_pkg::is_nan(err_q) &&
                    ((err_q > max_abs_q) || ((err_q == max_abs_q) && !worst_seen_q));
  assign take_rel = !tac_pkg::is_nan(rel_q) && (rel_q > max_rel_q);
  assign over_tol = !tac_pkg::is_nan(err_q) && !tac_pkg::is_nan(thr_q) &&
                    (thr_q[63] ? !(tac_pkg::is_zero(err_q) && tac_pkg::is_zero(thr_q))
                               : (err_q[62:0] > thr_q[62:0]));

  always_comb begin
    if (over_q != '0) begin
      verdict = tac_pkg::VERDICT_DIFFERENT;
    end else if (!exact_q) begin
      verdict = tac_pkg::VERDICT_WITHIN;
    end else begin
      verdict = tac_pkg::VERDICT_IDENTICAL;
    end
  end

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    pair_d       = pair_q;
    err_d        = err_q;
    thr_d        = thr_q;
    rel_d        = rel_q;
    res_d        = res_q;
    op_x_d       = op_x_q;
    op_y_d       = op_y_q;
    nsign_d      = nsign_q;
    nexp_d       = nexp_q;
    nmant_d      = nmant_q;
    nsticky_d    = nsticky_q;
    add_big_d    = add_big_q;
    add_small_d  = add_small_q;
    add_sub_d    = add_sub_q;
    acc_d        = acc_q;
    mcand_d      = mcand_q;
    mplier_d     = mplier_q;
    dvd_d        = dvd_q;
    dvd_exp_d    = dvd_exp_q;
    dvs_d        = dvs_q;
    rem_d        = rem_q;
    quo_d        = quo_q;
    step_d       = step_q;
    max_abs_d    = max_abs_q;
    max_rel_d    = max_rel_q;
    worst_seen_d = worst_seen_q;
    worst_at_d   = worst_at_q;
    over_d       = over_q;
    pairs_d      = pairs_q;
    exact_d      = exact_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !m_ready_i;
    pop_o        = 1'b0;

    unique case (state_q)
      tac_pkg::ST_IDLE: begin
        if (head_i.valid) begin
          pop_o   = 1'b1;
          pair_d  = head_i.pair;
          op_x_d  = head_i.pair.value_a;
          op_y_d  = {~head_i.pair.value_b[63], head_i.pair.value_b[62:0]};
          phase_d = tac_pkg::PH_ERR;
          state_d = tac_pkg::ST_ADD_ALIGN;
        end
      end

      tac_pkg::ST_ADD_ALIGN: begin
        state_d = tac_pkg::ST_STEP;
        if (tac_pkg::is_nan(op_x_q) || tac_pkg::is_nan(op_y_q) ||
            (tac_pkg::is_inf(op_x_q) && tac_pkg::is_inf(op_y_q) &&
             (op_x_q[63] != op_y_q[63]))) begin
          res_d = tac_pkg::QNAN;
        end else if (tac_pkg::is_inf(op_x_q)) begin
          res_d = op_x_q;
        end else if (tac_pkg::is_inf(op_y_q)) begin
          res_d = op_y_q;
        end else if (tac_pkg::is_zero(op_x_q) && tac_pkg::is_zero(op_y_q)) begin
          res_d = {op_x_q[63] & op_y_q[63], 63'd0};
        end else begin
          add_big_d   = {1'b0, tac_pkg::mant53(big), {(MW-54){1'b0}}};
          add_small_d = small_sh | MW'(align_lost);
          add_sub_d   = op_x_q[63] ^ op_y_q[63];
          nsign_d     = big[63];
          nexp_d      = tac_pkg::eff_exp(big) + EW'(1);
          state_d     = tac_pkg::ST_ADD_SUM;
        end
      end

      tac_pkg::ST_ADD_SUM: begin
        if (sum == '0) begin
          // exact cancellation rounds to +0
          res_d   = 64'd0;
          state_d = tac_pkg::ST_STEP;
        end else begin
          nmant_d   = sum;
          nsticky_d = 1'b0;
          state_d   = tac_pkg::ST_NORM;
        end
      end

      tac_pkg::ST_MUL_SETUP: begin
        state_d = tac_pkg::ST_STEP;
        if (tac_pkg::is_nan(op_x_q) || tac_pkg::is_nan(op_y_q) ||
            (tac_pkg::is_inf(op_x_q) && tac_pkg::is_zero(op_y_q)) ||
            (tac_pkg::is_zero(op_x_q) && tac_pkg::is_inf(op_y_q))) begin
          res_d = tac_pkg::QNAN;
        end else if (tac_pkg::is_inf(op_x_q) || tac_pkg::is_inf(op_y_q)) begin
          res_d = {op_x_q[63] ^ op_y_q[63], tac_pkg::POS_INF[62:0]};
        end else if (tac_pkg::is_zero(op_x_q) || tac_pkg::is_zero(op_y_q)) begin
          res_d = {op_x_q[63] ^ op_y_q[63], 63'd0};
        end else begin
          mcand_d   = tac_pkg::mant53(op_x_q);
          mplier_d  = tac_pkg::mant53(op_y_q);
          acc_d     = '0;
          step_d    = '0;
          nsign_d   = op_x_q[63] ^ op_y_q[63];
          nexp_d    = tac_pkg::eff_exp(op_x_q) + tac_pkg::eff_exp(op_y_q) + EW'(3);
          nsticky_d = 1'b0;
          state_d   = tac_pkg::ST_MUL;
        end
      end

      tac_pkg::ST_MUL: begin
        acc_d    = acc_next;
        mplier_d = {mplier_q[51:0], 1'b0};
        step_d   = step_q + 6'd1;
        if (step_q == 6'(tac_pkg::MUL_STEPS - 1)) begin
          nmant_d = {2'b00, acc_next};
          state_d = tac_pkg::ST_NORM;
        end
      end

      tac_pkg::ST_DIV_SETUP: begin
        phase_d = tac_pkg::PH_REL;
        state_d = tac_pkg::ST_STEP;
        if (tac_pkg::is_nan(err_q)) begin
          res_d = tac_pkg::QNAN;
        end else if (tac_pkg::is_inf(den)) begin
          res_d = tac_pkg::is_inf(err_q) ? tac_pkg::QNAN : 64'd0;
        end else if (tac_pkg::is_inf(err_q)) begin
          res_d = tac_pkg::POS_INF;
        end else if (tac_pkg::is_zero(err_q)) begin
          res_d = 64'd0;
        end else begin
          nsign_d   = 1'b0;
          nmant_d   = {tac_pkg::mant53(err_q), {(MW-53){1'b0}}};
          nexp_d    = tac_pkg::eff_exp(err_q);
          nsticky_d = 1'b0;
          phase_d   = tac_pkg::PH_DIVX;
          state_d   = tac_pkg::ST_NORM;
        end
      end

      tac_pkg::ST_DIV: begin
        rem_d  = {div_rem[52:0], 1'b0};
        quo_d  = {quo_q[54:0], div_ge};
        step_d = step_q + 6'd1;
        if (step_q == 6'(tac_pkg::DIV_STEPS - 1)) begin
          nmant_d   = {quo_q[54:0], div_ge, {(MW-56){1'b0}}};
          nsticky_d = div_rem != '0;
          phase_d   = tac_pkg::PH_REL;
          state_d   = tac_pkg::ST_NORM;
        end
      end

      tac_pkg::ST_NORM: begin
        if (nmant_q[MW-1]) begin
          priority case (phase_q)
            tac_pkg::PH_DIVX: begin
              dvd_d     = nmant_q[MW-1 -: 53];
              dvd_exp_d = nexp_q;
              nmant_d   = {tac_pkg::mant53(den), {(MW-53){1'b0}}};
              nexp_d    = tac_pkg::eff_exp(den);
              phase_d   = tac_pkg::PH_DIVY;
            end
            tac_pkg::PH_DIVY: begin
              dvs_d   = nmant_q[MW-1 -: 53];
              rem_d   = {1'b0, dvd_q};
              quo_d   = '0;
              step_d  = '0;
              nexp_d  = dvd_exp_q - nexp_q;
              state_d = tac_pkg::ST_DIV;
            end
            default: begin
              state_d = tac_pkg::ST_ROUND;
            end
          endcase
        end else if (nmant_q[MW-1 -: 8] == 8'd0) begin
          nmant_d = {nmant_q[MW-9:0], 8'd0};
          nexp_d  = nexp_q - EW'(8);
        end else begin
          nmant_d = {nmant_q[MW-2:0], 1'b0};
          nexp_d  = nexp_q - EW'(1);
        end
      end

      tac_pkg::ST_ROUND: begin
        res_d   = rnd;
        state_d = tac_pkg::ST_STEP;
      end

      tac_pkg::ST_STEP: begin
        unique case (phase_q)
          tac_pkg::PH_ERR: begin
            err_d   = {1'b0, res_q[62:0]};
            op_x_d  = rel_tol_i;
            op_y_d  = den;
            phase_d = tac_pkg::PH_PROD;
            state_d = tac_pkg::ST_MUL_SETUP;
          end
          tac_pkg::PH_PROD: begin
            op_x_d  = abs_tol_i;
            op_y_d  = res_q;
            phase_d = tac_pkg::PH_THR;
            state_d = tac_pkg::ST_ADD_ALIGN;
          end
          tac_pkg::PH_THR: begin
            thr_d = res_q;
            if (pair_q.den_pos) begin
              state_d = tac_pkg::ST_DIV_SETUP;
            end else begin
              rel_d   = 64'd0;
              state_d = tac_pkg::ST_UPDATE;
            end
          end
          tac_pkg::PH_REL: begin
            rel_d   = res_q;
            state_d = tac_pkg::ST_UPDATE;
          end
          default: begin
            state_d = tac_pkg::ST_IDLE;
          end
        endcase
      end

      tac_pkg::ST_UPDATE: begin
        if (pair_q.differ) begin
          exact_d = 1'b0;
        end
        if (take_abs) begin
          max_abs_d    = err_q;
          worst_at_d   = pairs_q;
          worst_seen_d = 1'b1;
        end
        if (take_rel) begin
          max_rel_d = rel_q;
        end
        if (over_tol && (over_q != cnt_max)) begin
          over_d = over_q + 1'b1;
        end
        if (pairs_q != cnt_max) begin
          pairs_d = pairs_q + 1'b1;
        end
        state_d = pair_q.last_pair ? tac_pkg::ST_EMIT : tac_pkg::ST_IDLE;
      end

      tac_pkg::ST_EMIT: begin
        if (!out_valid_q || m_ready_i) begin
          out_d.max_abs_error  = max_abs_q;
          out_d.max_rel_error  = max_rel_q;
          out_d.worst_position = worst_seen_q ? tac_pkg::clamp32(64'(worst_at_q)) : '1;
          out_d.exceed_count   = tac_pkg::clamp32(64'(over_q));
          out_d.all_exact      = exact_q;
          out_d.verdict        = verdict;
          out_valid_d          = 1'b1;
          max_abs_d            = 64'd0;
          max_rel_d            = 64'd0;
          worst_seen_d         = 1'b0;
          worst_at_d           = '0;
          over_d               = '0;
          pairs_d              = '0;
          exact_d              = 1'b1;
          state_d              = tac_pkg::ST_IDLE;
        end
      end

      default: begin
        state_d = tac_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tac_pkg::ST_IDLE;
      phase_q      <= tac_pkg::PH_ERR;
      out_valid_q  <= 1'b0;
      max_abs_q    <= 64'd0;
      max_rel_q    <= 64'd0;
      worst_seen_q <= 1'b0;
      worst_at_q   <= '0;
      over_q       <= '0;
      pairs_q      <= '0;
      exact_q      <= 1'b1;
      step_q       <= '0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      out_valid_q  <= out_valid_d;
      max_abs_q    <= max_abs_d;
      max_rel_q    <= max_rel_d;
      worst_seen_q <= worst_seen_d;
      worst_at_q   <= worst_at_d;
      over_q       <= over_d;
      pairs_q      <= pairs_d;
      exact_q      <= exact_d;
      step_q       <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pair_q      <= pair_d;
    err_q       <= err_d;
    thr_q       <= thr_d;
    rel_q       <= rel_d;
    res_q       <= res_d;
    op_x_q      <= op_x_d;
    op_y_q      <= op_y_d;
    nsign_q     <= nsign_d;
    nexp_q      <= nexp_d;
    nmant_q     <= nmant_d;
    nsticky_q   <= nsticky_d;
    add_big_q   <= add_big_d;
    add_small_q <= add_small_d;
    add_sub_q   <= add_sub_d;
    acc_q       <= acc_d;
    mcand_q     <= mcand_d;
    mplier_q    <= mplier_d;
    dvd_q       <= dvd_d;
    dvd_exp_q   <= dvd_exp_d;
    dvs_q       <= dvs_d;
    rem_q       <= rem_d;
    quo_q       <= quo_d;
    out_q       <= out_d;
  end

  assign m_valid_o = out_valid_q;
  assign result_o  = out_q;

endmodule

FILE: sv/tolerance_array_compare_top.sv
// ----------------------------------------------------------------------------
// tolerance_array_compare_top: streamed double array tolerance compare
// Compares pairs (a, b) of IEEE doubles against atol + rtol*|a| and reports
// the worst absolute and relative errors per array.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pair per request, tlast on the final pair of an array.
//   m_axis carries one summary request per array, after its final pair.
//   cfg writes abs_tolerance (index 0) and rel_tolerance (index 1) while the
//   block is idle; other indexes are dropped. cfg_ready_o is always high.
// Timing:
//   One pair at a time goes through a shared float unit. For ordinary values
//   the work is the 53-step shift-add multiply, the 56-step restoring divide
//   and the normalize shifts (up to 8 bits per cycle).
//   Subnormal operands or deep cancellation add normalize shifts; a NaN,
//   infinity or zero that skips the arithmetic shortens the work.
//   The summary is loaded in the emit state, after the final pair's update.
//   A two-entry queue takes new pairs while the unit is busy.
// Reset and stall:
//   Reset clears the tolerances to +0.0 and all running state. A stalled
//   summary stays in the output register; the next array keeps running and
//   waits only when its own summary is ready before the old one is taken.
// ----------------------------------------------------------------------------
module tolerance_array_compare_top #(
  parameter int unsigned COUNT_BITS = tac_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [127:0]                  s_axis_tdata_i,  // value_a [63:0], value_b [127:64]
  input  logic                          s_axis_tlast_i,  // last_pair
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // max_abs_error [63:0], max_rel_error [127:64], worst_position [159:128],
  // exceed_count [191:160], all_exact [192], verdict [194:193], zero [199:195]
  output logic [199:0]                  m_axis_tdata_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tac_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [63:0]                   cfg_data_i
);

  tac_pkg::queue_head_t head;
  tac_pkg::result_t     result;
  logic                 pop;
  logic [63:0]          abs_tol_q, rel_tol_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_tol_q <= 64'd0;
      rel_tol_q <= 64'd0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == tac_pkg::CFG_ABS_TOL) begin
        abs_tol_q <= cfg_data_i;
      end
      if (cfg_index_i == tac_pkg::CFG_REL_TOL) begin
        rel_tol_q <= cfg_data_i;
      end
    end
  end

  tac_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tlast_i  (s_axis_tlast_i),
    .head_o          (head),
    .pop_i           (pop)
  );

  tac_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .pop_o     (pop),
    .abs_tol_i (abs_tol_q),
    .rel_tol_i (rel_tol_q),
    .m_valid_o (m_axis_tvalid_o),
    .m_ready_i (m_axis_tready_i),
    .result_o  (result)
  );

  assign m_axis_tdata_o = {5'd0, result.verdict, result.all_exact, result.exceed_count,
                           result.worst_position, result.max_rel_error,
                           result.max_abs_error};

endmodule
